// ----- rtl/kheap_pkg.sv -----
// Package for the k-ary heap sorter: data type and arity constants.
// No dependencies; used by kary_heap_sorter.
package kheap_pkg;

    typedef logic signed [31:0] data_t;

    localparam int ARITY_W = 4;
    localparam logic [ARITY_W-1:0] ARITY_MIN   = 4'd1;
    localparam logic [ARITY_W-1:0] ARITY_MAX   = 4'd8;
    localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

endpackage

// ----- rtl/kary_heap_sorter.sv -----
// Heap sort of a set of signed 32-bit values over one shared compare unit and one store.
// Depends on kheap_pkg. Loading: one item per cycle, ready high until the item marked last.
// Sorting: a build step per node, from the last down to the root, each a sift-down that reads
//   the node, compares each child in turn and swaps; extraction swaps root and last item.
// Output: each result is read, registered and held until m_ready; not ready for input meanwhile.
// Reset: count, dropped flag and sequencer cleared, arity set to 2; store contents undefined.
module kary_heap_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kheap_pkg::ARITY_W-1:0] cfg_arity,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_value,
    input  logic                        s_last_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_sorted_value,
    output logic                        m_last_result,
    output logic                        m_overflowed
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int BW = AW + kheap_pkg::ARITY_W;
    localparam int XW = BW + 1;

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_BUILD     = 4'd1;
    localparam logic [3:0] S_SIFT_RD   = 4'd2;
    localparam logic [3:0] S_SIFT_NODE = 4'd3;
    localparam logic [3:0] S_CHILD     = 4'd4;
    localparam logic [3:0] S_CMP       = 4'd5;
    localparam logic [3:0] S_SWAP_A    = 4'd6;
    localparam logic [3:0] S_SWAP_B    = 4'd7;
    localparam logic [3:0] S_EXT       = 4'd8;
    localparam logic [3:0] S_EXT_A     = 4'd9;
    localparam logic [3:0] S_EXT_B     = 4'd10;
    localparam logic [3:0] S_EXT_C     = 4'd11;
    localparam logic [3:0] S_OUT_RD    = 4'd12;
    localparam logic [3:0] S_OUT_LD    = 4'd13;
    localparam logic [3:0] S_OUT_WAIT  = 4'd14;

    kheap_pkg::data_t mem [MAX_ITEMS];
    kheap_pkg::data_t rdata_reg;

    logic [3:0]                    state_reg, state_next;
    logic [kheap_pkg::ARITY_W-1:0] arity_reg, arity_next;
    logic [kheap_pkg::ARITY_W-1:0] k_reg, k_next;
    logic [kheap_pkg::ARITY_W-1:0] j_reg, j_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 n_reg, n_next;
    logic [CW-1:0]                 size_reg, size_next;
    logic [CW-1:0]                 i_reg, i_next;
    logic                          dropped_reg, dropped_next;
    logic                          extract_reg, extract_next;
    logic [AW-1:0]                 node_reg, node_next;
    logic [AW-1:0]                 best_idx_reg, best_idx_next;
    logic [AW-1:0]                 cidx_reg, cidx_next;
    logic [AW-1:0]                 oidx_reg, oidx_next;
    logic [BW-1:0]                 base_reg, base_next;
    kheap_pkg::data_t              node_val_reg, node_val_next;
    kheap_pkg::data_t              best_val_reg, best_val_next;
    kheap_pkg::data_t              out_val_reg, out_val_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_ovf_reg, out_ovf_next;

    logic                          we;
    logic [AW-1:0]                 waddr, raddr;
    kheap_pkg::data_t              wdata;
    logic [XW-1:0]                 child;
    logic                          has_room;
    logic [CW-1:0]                 n_close;
    logic [kheap_pkg::ARITY_W-1:0] k_clamped;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == S_LOAD);
    assign m_valid        = (state_reg == S_OUT_WAIT);
    assign m_sorted_value = out_val_reg;
    assign m_last_result  = out_last_reg;
    assign m_overflowed   = out_ovf_reg;

    assign child    = XW'(base_reg) + XW'(j_reg);
    assign has_room = (count_reg < CW'(MAX_ITEMS));
    assign n_close  = has_room ? (count_reg + CW'(1)) : count_reg;

    always_comb begin
        if (arity_reg < kheap_pkg::ARITY_MIN) begin
            k_clamped = kheap_pkg::ARITY_MIN;
        end else if (arity_reg > kheap_pkg::ARITY_MAX) begin
            k_clamped = kheap_pkg::ARITY_MAX;
        end else begin
            k_clamped = arity_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        arity_next    = arity_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        size_next     = size_reg;
        i_next        = i_reg;
        dropped_next  = dropped_reg;
        extract_next  = extract_reg;
        node_next     = node_reg;
        best_idx_next = best_idx_reg;
        cidx_next     = cidx_reg;
        oidx_next     = oidx_reg;
        base_next     = base_reg;
        node_val_next = node_val_reg;
        best_val_next = best_val_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        out_ovf_next  = out_ovf_reg;
        we            = 1'b0;
        waddr         = count_reg[AW-1:0];
        wdata         = s_value;
        raddr         = node_reg;

        if (cfg_valid) begin
            arity_next = cfg_arity;
        end

        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (has_room) begin
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last_item) begin
                        k_next       = k_clamped;
                        n_next       = n_close;
                        size_next    = n_close;
                        i_next       = n_close;
                        extract_next = 1'b0;
                        state_next   = S_BUILD;
                    end
                end
            end
            S_BUILD: begin
                if (i_reg == '0) begin
                    i_next       = n_reg - CW'(1);
                    extract_next = 1'b1;
                    state_next   = S_EXT;
                end else begin
                    i_next     = i_reg - CW'(1);
                    node_next  = AW'(i_reg - CW'(1));
                    state_next = S_SIFT_RD;
                end
            end
            S_SIFT_RD: begin
                raddr      = node_reg;
                base_next  = BW'(k_reg) * BW'(node_reg);
                state_next = S_SIFT_NODE;
            end
            S_SIFT_NODE: begin
                node_val_next = rdata_reg;
                best_val_next = rdata_reg;
                best_idx_next = node_reg;
                j_next        = kheap_pkg::ARITY_W'(1);
                state_next    = S_CHILD;
            end
            S_CHILD: begin
                if (j_reg <= k_reg && child < XW'(size_reg)) begin
                    raddr      = child[AW-1:0];
                    cidx_next  = child[AW-1:0];
                    state_next = S_CMP;
                end else if (best_idx_reg == node_reg) begin
                    state_next = extract_reg ? S_EXT : S_BUILD;
                end else begin
                    state_next = S_SWAP_A;
                end
            end
            S_CMP: begin
                if (rdata_reg > best_val_reg) begin
                    best_val_next = rdata_reg;
                    best_idx_next = cidx_reg;
                end
                j_next     = j_reg + kheap_pkg::ARITY_W'(1);
                state_next = S_CHILD;
            end
            S_SWAP_A: begin
                we         = 1'b1;
                waddr      = node_reg;
                wdata      = best_val_reg;
                state_next = S_SWAP_B;
            end
            S_SWAP_B: begin
                we         = 1'b1;
                waddr      = best_idx_reg;
                wdata      = node_val_reg;
                node_next  = best_idx_reg;
                state_next = S_SIFT_RD;
            end
            S_EXT: begin
                if (i_reg == '0) begin
                    oidx_next  = '0;
                    state_next = S_OUT_RD;
                end else begin
                    raddr      = '0;
                    state_next = S_EXT_A;
                end
            end
            S_EXT_A: begin
                node_val_next = rdata_reg;
                raddr         = i_reg[AW-1:0];
                state_next    = S_EXT_B;
            end
            S_EXT_B: begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = rdata_reg;
                state_next = S_EXT_C;
            end
            S_EXT_C: begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = node_val_reg;
                size_next  = i_reg;
                i_next     = i_reg - CW'(1);
                node_next  = '0;
                state_next = S_SIFT_RD;
            end
            S_OUT_RD: begin
                raddr      = oidx_reg;
                state_next = S_OUT_LD;
            end
            S_OUT_LD: begin
                out_val_next  = rdata_reg;
                out_last_next = ((CW'(oidx_reg) + CW'(1)) == n_reg);
                out_ovf_next  = dropped_reg;
                state_next    = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_ready) begin
                    if (out_last_reg) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_LOAD;
                    end else begin
                        oidx_next  = oidx_reg + AW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            arity_reg   <= kheap_pkg::ARITY_RESET;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            extract_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            arity_reg   <= arity_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            extract_reg <= extract_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        j_reg        <= j_next;
        n_reg        <= n_next;
        size_reg     <= size_next;
        i_reg        <= i_next;
        node_reg     <= node_next;
        best_idx_reg <= best_idx_next;
        cidx_reg     <= cidx_next;
        oidx_reg     <= oidx_next;
        base_reg     <= base_next;
        node_val_reg <= node_val_next;
        best_val_reg <= best_val_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for kary_heap_sorter: sends sets of signed values, predicts the
// ascending output of each set with its own k-ary heap sort and checks every result transfer.
// Depends on kheap_pkg and the kary_heap_sorter RTL.
module testbench;

    localparam int CAPACITY     = 64;
    localparam int PHASES       = 8;
    localparam int SMALL_ITEMS  = 12;
    localparam int SETTLE       = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_AT      = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    localparam logic [kheap_pkg::ARITY_W-1:0] PHASE_ARITY [PHASES] = '{
        4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd12, 4'd5, 4'd2
    };

    typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGE} spread_e;

    typedef struct packed {
        kheap_pkg::data_t value;
        logic             last;
        logic             ovf;
    } sorted_t;

    class sort_scoreboard;
        kheap_pkg::data_t              store [CAPACITY];
        int unsigned                   fill;
        bit                            lost;
        logic [kheap_pkg::ARITY_W-1:0] arity;
        sorted_t                       sorted_q [$];
        int                            errors;
        int                            items_noted;
        int                            sets_closed;
        int                            results_checked;

        function new();
            fill            = 0;
            lost            = 1'b0;
            arity           = kheap_pkg::ARITY_RESET;
            errors          = 0;
            items_noted     = 0;
            sets_closed     = 0;
            results_checked = 0;
        endfunction

        function void set_arity(logic [kheap_pkg::ARITY_W-1:0] a);
            arity = a;
        endfunction

        function int unsigned pending();
            return sorted_q.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_MAX) $display("%s", msg);
        endfunction

        function void sift(int unsigned root, int unsigned size, int unsigned k);
            int unsigned      node;
            int unsigned      best;
            int unsigned      c;
            int unsigned      j;
            kheap_pkg::data_t t;
            bit               moving;
            node   = root;
            moving = 1'b1;
            while (moving) begin
                best = node;
                for (j = 1; j <= k; j++) begin
                    c = k * node + j;
                    if (c < size && store[c] > store[best]) best = c;
                end
                if (best == node) begin
                    moving = 1'b0;
                end else begin
                    t           = store[node];
                    store[node] = store[best];
                    store[best] = t;
                    node        = best;
                end
            end
        endfunction

        function void note_input(kheap_pkg::data_t v, logic last);
            int unsigned      k;
            int unsigned      n;
            int unsigned      i;
            kheap_pkg::data_t t;
            sorted_t          r;
            items_noted++;
            if (fill < CAPACITY) begin
                store[fill] = v;
                fill++;
            end else begin
                lost = 1'b1;
            end
            if (!last) return;
            if (arity < kheap_pkg::ARITY_MIN) k = kheap_pkg::ARITY_MIN;
            else if (arity > kheap_pkg::ARITY_MAX) k = kheap_pkg::ARITY_MAX;
            else k = arity;
            n = fill;
            i = (n - 1) / k + 1;
            while (i > 0) begin
                i--;
                sift(i, n, k);
            end
            for (i = n - 1; i > 0; i--) begin
                t        = store[0];
                store[0] = store[i];
                store[i] = t;
                sift(0, i, k);
            end
            for (i = 0; i < n; i++) begin
                r.value = store[i];
                r.last  = (i + 1 == n);
                r.ovf   = lost;
                sorted_q.push_back(r);
            end
            fill = 0;
            lost = 1'b0;
            sets_closed++;
        endfunction

        function void check_result(kheap_pkg::data_t v, logic last, logic ovf);
            sorted_t e;
            results_checked++;
            if (sorted_q.size() == 0) begin
                report($sformatf("unexpected result: value %0d last %0b ovf %0b", v, last, ovf));
                return;
            end
            e = sorted_q.pop_front();
            if (v !== e.value || last !== e.last || ovf !== e.ovf)
                report($sformatf({"result %0d: expected value %0d last %0b ovf %0b, ",
                                  "got value %0d last %0b ovf %0b"}, results_checked,
                                 e.value, e.last, e.ovf, v, last, ovf));
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [kheap_pkg::ARITY_W-1:0] cfg_arity;
    logic                          s_valid;
    logic                          s_ready;
    kheap_pkg::data_t              s_value;
    logic                          s_last_item;
    logic                          m_valid;
    logic                          m_ready;
    kheap_pkg::data_t              m_sorted_value;
    logic                          m_last_result;
    logic                          m_overflowed;

    sort_scoreboard sb = new();
    bit             steady;
    bit             held;
    int             results_seen;

    kary_heap_sorter #(
        .MAX_ITEMS(CAPACITY)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_arity     (cfg_arity),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_result (m_last_result),
        .m_overflowed  (m_overflowed)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic kheap_pkg::data_t pick_value(spread_e kind);
        case (kind)
            SPREAD_NARROW: return kheap_pkg::data_t'($urandom_range(0, 6)) - 3;
            SPREAD_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFFFFFF;
                    1:       return 32'sh80000000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return kheap_pkg::data_t'($urandom);
        endcase
    endfunction

    function automatic spread_e pick_spread();
        int unsigned r;
        r = $urandom_range(0, 5);
        if (r < 4) return SPREAD_FULL;
        if (r == 4) return SPREAD_NARROW;
        return SPREAD_EDGE;
    endfunction

    task automatic send_item(kheap_pkg::data_t v, logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_value     <= v;
        s_last_item <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(v, last);
    endtask

    task automatic send_set(int n, spread_e kind);
        for (int i = 0; i < n; i++) send_item(pick_value(kind), i == n - 1);
    endtask

    // hold until every sorted value has been transferred and the block is back to loading
    task automatic settle(int cycles);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic write_arity(logic [kheap_pkg::ARITY_W-1:0] a);
        cfg_valid <= 1'b1;
        cfg_arity <= a;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_arity(a);
    endtask

    initial begin : result_sink
        int wait_cycles;
        m_ready      <= 1'b0;
        held         = 1'b0;
        results_seen = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_seen == HOLD_AT && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            wait_cycles = steady ? 0 : $urandom_range(0, 4);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_result(m_sorted_value, m_last_result, m_overflowed);
            results_seen++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("kary_heap_sorter verification failed");
        $finish;
    end

    initial begin : stimulus
        int budget;
        int size;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_arity   <= kheap_pkg::ARITY_RESET;
        s_valid     <= 1'b0;
        s_value     <= '0;
        s_last_item <= 1'b0;
        steady      = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed sets at the reset arity: lone extremes, mixed extremes, duplicates, reversed
        send_item(32'sh7FFFFFFF, 1'b1);
        send_item(32'sh80000000, 1'b1);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh7FFFFFFF, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sd1, 1'b1);
        for (int i = 0; i < 6; i++) send_item((i % 2 == 0) ? 32'sd5 : -32'sd5, i == 5);
        for (int i = 6; i > 0; i--) send_item(kheap_pkg::data_t'(i), i == 1);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle(SETTLE);
            write_arity(PHASE_ARITY[ph]);
            steady = (ph % 3 == 1);
            case (ph)
                1: send_set(CAPACITY, pick_spread());
                2: send_set(CAPACITY + 1, pick_spread());
                4: send_set(CAPACITY + 2, pick_spread());
                default: ;
            endcase
            budget = 0;
            while (budget < SMALL_ITEMS) begin
                size = $urandom_range(1, 8);
                send_set(size, pick_spread());
                budget += size;
            end
        end

        settle(DRAIN_CYCLES);
        if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d items in %0d sets, %0d results checked, %0d arity settings",
                 sb.items_noted, sb.sets_closed, sb.results_checked, PHASES + 1);
        $display("included full and overfull sets, arity 0 and above 8, long output hold-off");
        if (sb.errors == 0) begin
            $display("kary_heap_sorter verification clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("kary_heap_sorter verification failed");
        end
        $finish;
    end
endmodule

// ----- kary_heap_sorter.f -----
rtl/kheap_pkg.sv
rtl/kary_heap_sorter.sv
sim/testbench.sv
